// ===== rtl/atr_pkg.sv =====
// ----------------------------------------------------------------------------
// ATR package
// Shared constants, controller states and command/status bundles for the
// average true range block.
// ----------------------------------------------------------------------------
package atr_pkg;

  localparam int unsigned MAX_WINDOW   = 64;
  localparam int unsigned PRICE_BITS   = 32;
  localparam int unsigned FRAC_BITS    = 8;
  localparam int unsigned CFG_BITS     = 7;
  localparam int unsigned ATR_BITS     = 40;
  localparam int unsigned PTR_BITS     = $clog2(MAX_WINDOW);
  localparam int unsigned WIN_BITS     = $clog2(MAX_WINDOW + 2);
  localparam int unsigned SUM_BITS     = PRICE_BITS + PTR_BITS;
  localparam int unsigned DIV_STEPS    = SUM_BITS + FRAC_BITS;
  localparam int unsigned DIV_CNT_BITS = $clog2(DIV_STEPS);

  localparam logic [CFG_BITS-1:0] RESET_WINDOW = CFG_BITS'(14);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RANGE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } atr_state_e;

  typedef struct packed {
    logic load;
    logic cfg_wr;
    logic calc_tr;
    logic update;
    logic div_step;
    logic out_load;
  } atr_cmd_t;

  typedef struct packed {
    logic res_valid;
    logic div_last;
  } atr_status_t;

endpackage

// ===== rtl/atr_if.sv =====
// ----------------------------------------------------------------------------
// ATR channel interfaces
// Valid/ready channels for price bars, results and the window register.
// ----------------------------------------------------------------------------
interface atr_bar_if import atr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  first_bar;
  logic [PRICE_BITS-1:0] high_price;
  logic [PRICE_BITS-1:0] low_price;
  logic [PRICE_BITS-1:0] close_price;

  modport source (output valid, first_bar, high_price, low_price, close_price, input ready);
  modport sink   (input valid, first_bar, high_price, low_price, close_price, output ready);
endinterface

interface atr_res_if import atr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ATR_BITS-1:0] atr_value;
  logic                valid_res;

  modport source (output valid, atr_value, valid_res, input ready);
  modport sink   (input valid, atr_value, valid_res, output ready);
endinterface

interface atr_cfg_if import atr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] window_length;

  modport source (output valid, window_length, input ready);
  modport sink   (input valid, window_length, output ready);
endinterface

// ===== rtl/atr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data, no reset.
// ----------------------------------------------------------------------------
module atr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/atr_ctrl.sv =====
// ----------------------------------------------------------------------------
// ATR controller
// Sequences one bar: range, window update, divide, then result hand-off.
// ----------------------------------------------------------------------------
module atr_ctrl import atr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        bar_valid_i,
  output logic        bar_ready_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        res_ready_i,
  output logic        res_valid_o,
  input  atr_status_t status_i,
  output atr_cmd_t    cmd_o
);

  atr_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    bar_ready_o = 1'b0;
    cfg_ready_o = 1'b1;
    out_valid_d = out_valid_q && !res_ready_i;

    cmd_o.cfg_wr = cfg_valid_i;

    case (state_q)
      ST_IDLE: begin
        bar_ready_o = 1'b1;
        if (bar_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RANGE;
        end
      end
      ST_RANGE: begin
        cmd_o.calc_tr = 1'b1;
        state_d       = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        // skip the divide when no valid average is due
        if (!status_i.res_valid) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.div_step = 1'b1;
          if (status_i.div_last) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || res_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_valid_o = out_valid_q;

endmodule

// ===== rtl/atr_dp.sv =====
// ----------------------------------------------------------------------------
// ATR datapath
// True range, range ring, running window sum and a radix-2 restoring
// divider by the window length.
// ----------------------------------------------------------------------------
module atr_dp import atr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  atr_cmd_t              cmd_i,
  output atr_status_t           status_o,
  input  logic [CFG_BITS-1:0]   window_length_i,
  input  logic                  first_bar_i,
  input  logic [PRICE_BITS-1:0] high_price_i,
  input  logic [PRICE_BITS-1:0] low_price_i,
  input  logic [PRICE_BITS-1:0] close_price_i,
  output logic [ATR_BITS-1:0]   atr_value_o,
  output logic                  valid_res_o
);

  logic [CFG_BITS-1:0]     win_len_q;
  logic [PRICE_BITS-1:0]   prev_close_q;
  logic [WIN_BITS-1:0]     bar_count_q, bar_count_d;
  logic [PTR_BITS-1:0]     ptr_q;
  logic [SUM_BITS-1:0]     sum_q, sum_d;
  logic                    valid_q;

  logic [PRICE_BITS-1:0]   hi_q, lo_q, cl_q;
  logic [PRICE_BITS-1:0]   tr_q, tr_d;

  logic [DIV_STEPS-1:0]    dvd_q;
  logic [WIN_BITS-1:0]     rem_q, rem_d;
  logic [DIV_CNT_BITS-1:0] div_cnt_q;
  logic [WIN_BITS:0]       trial;
  logic                    qbit;

  logic [ATR_BITS-1:0]     atr_q;
  logic                    valid_res_q;

  logic [WIN_BITS-1:0]     n_eff, n_plus1, cnt_inc;
  logic                    full;
  logic [PTR_BITS:0]       ptr_inc;
  logic [PTR_BITS-1:0]     ptr_next;
  logic [PRICE_BITS-1:0]   d_hl, d_hc, d_lc;
  logic [PRICE_BITS-1:0]   ring_rdata;
  logic                    ring_we;

  // 0 acts as 1, anything above the ring depth as the depth
  always_comb begin
    if (win_len_q == '0) begin
      n_eff = WIN_BITS'(1);
    end else if (WIN_BITS'(win_len_q) > WIN_BITS'(MAX_WINDOW)) begin
      n_eff = WIN_BITS'(MAX_WINDOW);
    end else begin
      n_eff = WIN_BITS'(win_len_q);
    end
  end

  assign n_plus1 = n_eff + WIN_BITS'(1);
  assign full    = bar_count_q >= n_plus1;
  assign cnt_inc = bar_count_q + WIN_BITS'(1);

  // true range from the latched bar and the previous close
  always_comb begin
    d_hl = (hi_q >= lo_q) ? hi_q - lo_q : '0;
    d_hc = (hi_q >= prev_close_q) ? hi_q - prev_close_q : prev_close_q - hi_q;
    d_lc = (lo_q >= prev_close_q) ? lo_q - prev_close_q : prev_close_q - lo_q;
    tr_d = d_hl;
    if (d_hc > tr_d) begin
      tr_d = d_hc;
    end
    if (d_lc > tr_d) begin
      tr_d = d_lc;
    end
  end

  assign ptr_inc  = {1'b0, ptr_q} + (PTR_BITS+1)'(1);
  assign ptr_next = (WIN_BITS'(ptr_inc) >= n_eff) ? '0 : ptr_inc[PTR_BITS-1:0];
  assign ring_we  = cmd_i.update && (bar_count_q != '0);

  always_comb begin
    sum_d = sum_q;
    if (bar_count_q != '0) begin
      sum_d = sum_q + SUM_BITS'(tr_q)
            - (full ? SUM_BITS'(ring_rdata) : SUM_BITS'(0));
    end
    bar_count_d = (cnt_inc > n_plus1) ? n_plus1 : cnt_inc;
  end

  atr_ram #(
    .WIDTH (PRICE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ptr_q),
    .wdata_i (tr_q),
    .re_i    (cmd_i.load),
    .raddr_i (first_bar_i ? PTR_BITS'(0) : ptr_q),
    .rdata_o (ring_rdata)
  );

  // one quotient bit per step; the quotient shifts in behind the dividend
  assign trial = {rem_q, dvd_q[DIV_STEPS-1]};
  assign qbit  = trial >= {1'b0, n_eff};
  assign rem_d = qbit ? WIN_BITS'(trial - {1'b0, n_eff}) : WIN_BITS'(trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q    <= RESET_WINDOW;
      prev_close_q <= '0;
      bar_count_q  <= '0;
      ptr_q        <= '0;
      sum_q        <= '0;
      valid_q      <= 1'b0;
      div_cnt_q    <= '0;
    end else begin
      if (cmd_i.cfg_wr) begin
        win_len_q   <= window_length_i;
        bar_count_q <= '0;
        ptr_q       <= '0;
        sum_q       <= '0;
      end
      if (cmd_i.load && first_bar_i) begin
        bar_count_q <= '0;
        ptr_q       <= '0;
        sum_q       <= '0;
      end
      if (cmd_i.update) begin
        valid_q      <= full;
        sum_q        <= sum_d;
        bar_count_q  <= bar_count_d;
        prev_close_q <= cl_q;
        div_cnt_q    <= '0;
        if (bar_count_q != '0) begin
          ptr_q <= ptr_next;
        end
      end
      if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hi_q <= high_price_i;
      lo_q <= low_price_i;
      cl_q <= close_price_i;
    end
    if (cmd_i.calc_tr) begin
      tr_q <= tr_d;
    end
    if (cmd_i.update) begin
      dvd_q <= {sum_d, FRAC_BITS'(0)};
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[DIV_STEPS-2:0], qbit};
      rem_q <= rem_d;
    end
    if (cmd_i.out_load) begin
      atr_q       <= valid_q ? dvd_q[ATR_BITS-1:0] : '0;
      valid_res_q <= valid_q;
    end
  end

  assign status_o.res_valid = valid_q;
  assign status_o.div_last  = div_cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1);
  assign atr_value_o        = atr_q;
  assign valid_res_o        = valid_res_q;

endmodule

// ===== rtl/average_true_range_sma.sv =====
// Sequence: a bar request is taken in idle, then range, update, 46 divide steps
//   (skipped when no valid average is due) and hand-off to the output register.
// Throughput: a new bar is taken only once the last one is handed off; the
//   restoring divider by the window length makes one quotient bit per cycle.
// Reset: window length 14, series empty; the range ring is not cleared.
// ----------------------------------------------------------------------------
// Average true range, simple moving window
// Top level: joins the controller, the datapath and the channel interfaces.
// ----------------------------------------------------------------------------
module average_true_range_sma import atr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  atr_bar_if.sink   bar_i,
  atr_cfg_if.sink   cfg_i,
  atr_res_if.source res_o
);

  atr_cmd_t    cmd;
  atr_status_t status;

  atr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bar_valid_i (bar_i.valid),
    .bar_ready_o (bar_i.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .res_ready_i (res_o.ready),
    .res_valid_o (res_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  atr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .window_length_i (cfg_i.window_length),
    .first_bar_i     (bar_i.first_bar),
    .high_price_i    (bar_i.high_price),
    .low_price_i     (bar_i.low_price),
    .close_price_i   (bar_i.close_price),
    .atr_value_o     (res_o.atr_value),
    .valid_res_o     (res_o.valid_res)
  );

endmodule
